/* design/wc_pkg.sv */
// wc_pkg: shared constants, types and config register codes of the 3x3 window filter.
// No dependencies; every other file of the block imports it.
package wc_pkg;

    localparam int MAX_LINE  = 1024;           // longest line held in the line memory
    localparam int ROW_LIMIT = 1024;           // tallest frame
    localparam int COEF_BITS = 12;             // signed kernel coefficient width
    localparam int FRAC_BITS = 8;              // fraction bits of a coefficient

    localparam int PIX_W     = 8;
    localparam int COL_W     = $clog2(MAX_LINE);
    localparam int ROW_W     = $clog2(ROW_LIMIT);
    localparam int DIM_W     = $clog2(MAX_LINE + 1);
    localparam int DIMH_W    = $clog2(ROW_LIMIT + 1);
    localparam int CFG_DIM_W = 11;
    localparam int OUT_POS_W = 10;
    localparam int LINE_DW   = 2 * PIX_W;      // upper and lower line packed in one word

    localparam int KROW_W    = 36;
    localparam int KEXT_W    = (3 * COEF_BITS > KROW_W) ? 3 * COEF_BITS : KROW_W;
    localparam int PROD_W    = PIX_W + 1 + COEF_BITS;
    localparam int ROWSUM_W  = PROD_W + 2;
    localparam int SUM_W     = PROD_W + 4;
    localparam int SOB_W     = PIX_W + 3;
    localparam int MAG_W     = PIX_W + 3;
    localparam int PIX_MAX   = (1 << PIX_W) - 1;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 36;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MIDDLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd6;

    localparam logic MODE_KERNEL = 1'b0;
    localparam logic MODE_SOBEL  = 1'b1;

    localparam logic [KROW_W-1:0]    KERNEL_RESET = 36'h01C01C01C;
    localparam logic [PIX_W-1:0]     THRESH_RESET = 8'd100;
    localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 11'd320;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 11'd240;

    // 3x3 window, entry row*3+col, top left first
    typedef logic [8:0][PIX_W-1:0] t_window;

    typedef struct packed {
        logic                 done;
        logic [OUT_POS_W-1:0] col;
        logic [OUT_POS_W-1:0] row;
    } t_pos_meta;

    typedef struct packed {
        logic                 done;
        logic [OUT_POS_W-1:0] col;
        logic [OUT_POS_W-1:0] row;
        logic [PIX_W-1:0]     pix;
    } t_result;

endpackage

/* design/wc_line_ram.sv */
// wc_line_ram: single-port-read, single-port-write line memory, one word per column.
// Word holds upper line in the high byte, lower line in the low byte. Uses wc_pkg.
module wc_line_ram (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [wc_pkg::COL_W-1:0]    i_rd_addr,
    output logic [wc_pkg::LINE_DW-1:0]  o_rd_data,
    input  logic                        i_wr_en,
    input  logic [wc_pkg::COL_W-1:0]    i_wr_addr,
    input  logic [wc_pkg::LINE_DW-1:0]  i_wr_data
);
    import wc_pkg::*;

    logic [LINE_DW-1:0] mem [MAX_LINE];
    logic [LINE_DW-1:0] r_rd_data;

    // read-first: a same-address write lands after the read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/wc_front.sv */
// wc_front: raster position, line memory read-modify-write with forwarding, 3x3 window.
// Depends on wc_pkg and wc_line_ram.
module wc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_pix_valid,
    input  logic [wc_pkg::PIX_W-1:0]    i_pix,
    input  logic                        i_frame_start,
    input  logic [wc_pkg::DIM_W-1:0]    i_width,
    input  logic [wc_pkg::DIMH_W-1:0]   i_height,
    output logic                        o_win_valid,
    output wc_pkg::t_window             o_window,
    output wc_pkg::t_pos_meta           o_meta
);
    import wc_pkg::*;

    logic               accept;
    logic [COL_W-1:0]   c0;
    logic [ROW_W-1:0]   r0;
    logic               col_last;
    logic               row_last;
    logic               emit0;
    t_pos_meta          meta0;
    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;

    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;

    logic               r_s1_valid;
    logic [COL_W-1:0]   r_s1_col;
    logic [PIX_W-1:0]   r_s1_pix;
    logic               r_s1_emit;
    t_pos_meta          r_s1_meta;
    logic               r_s1_fwd;
    logic [LINE_DW-1:0] r_s1_fwd_data;

    logic [LINE_DW-1:0] ram_q;
    logic [LINE_DW-1:0] line_word;
    logic [PIX_W-1:0]   up;
    logic [PIX_W-1:0]   lo;
    logic [LINE_DW-1:0] wr_data;
    logic               wr_en;

    t_window            r_window;
    t_window            n_window;
    logic               r_s2_valid;
    t_pos_meta          r_s2_meta;

    assign accept = i_pix_valid & i_en;

    always_comb begin
        c0       = i_frame_start ? '0 : r_col;
        r0       = i_frame_start ? '0 : r_row;
        col_last = DIM_W'(c0) >= i_width - DIM_W'(1);
        row_last = DIMH_W'(r0) >= i_height - DIMH_W'(1);
        emit0    = (c0 >= COL_W'(2)) && (r0 >= ROW_W'(2))
                && (DIM_W'(c0) < i_width) && (DIMH_W'(r0) < i_height);
        meta0.row  = OUT_POS_W'(r0 - ROW_W'(1));
        meta0.col  = OUT_POS_W'(c0 - COL_W'(1));
        meta0.done = (DIM_W'(c0) == i_width - DIM_W'(1))
                  && (DIMH_W'(r0) == i_height - DIMH_W'(1));
        n_col = col_last ? '0 : c0 + COL_W'(1);
        if (col_last) begin
            n_row = row_last ? '0 : r0 + ROW_W'(1);
        end else begin
            n_row = r0;
        end
    end

    // read the column on accept, write it back from the stage-1 registers
    assign line_word = r_s1_fwd ? r_s1_fwd_data : ram_q;
    assign up        = line_word[LINE_DW-1:PIX_W];
    assign lo        = line_word[PIX_W-1:0];
    assign wr_data   = {lo, r_s1_pix};
    assign wr_en     = r_s1_valid & i_en;

    wc_line_ram u_line_ram (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (c0),
        .o_rd_data (ram_q),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_data)
    );

    always_comb begin
        n_window = r_window;
        for (int k = 0; k < 3; k++) begin
            n_window[k*3]     = r_window[k*3 + 1];
            n_window[k*3 + 1] = r_window[k*3 + 2];
        end
        n_window[2] = up;
        n_window[5] = lo;
        n_window[8] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_pix_valid;
            r_s2_valid <= r_s1_valid & r_s1_emit;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (accept) begin
                r_s1_col      <= c0;
                r_s1_pix      <= i_pix;
                r_s1_emit     <= emit0;
                r_s1_meta     <= meta0;
                // same column written this edge: memory returns stale data
                r_s1_fwd      <= r_s1_valid && (r_s1_col == c0);
                r_s1_fwd_data <= wr_data;
            end
            if (r_s1_valid) begin
                r_window  <= n_window;
                r_s2_meta <= r_s1_meta;
            end
        end
    end

    assign o_win_valid = r_s2_valid;
    assign o_window    = r_window;
    assign o_meta      = r_s2_meta;

    a_fwd_on_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_s1_valid && (r_s1_col == c0)) |=> r_s1_fwd)
        else $error("line memory collision not forwarded");

    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_s2_meta.row != '0) && (r_s2_meta.col != '0))
        else $error("border pixel reached the arithmetic");

    a_pos_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_col) && $stable(r_row))
        else $error("raster position moved during a stall");

endmodule

/* design/wc_datapath.sv */
// wc_datapath: kernel products and Sobel gradients, row sums, truncation and saturation.
// Two register stages; depends on wc_pkg.
module wc_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  wc_pkg::t_window             i_window,
    input  wc_pkg::t_pos_meta           i_meta,
    input  logic                        i_mode,
    input  logic [wc_pkg::KROW_W-1:0]   i_kernel_top,
    input  logic [wc_pkg::KROW_W-1:0]   i_kernel_middle,
    input  logic [wc_pkg::KROW_W-1:0]   i_kernel_bottom,
    input  logic [wc_pkg::PIX_W-1:0]    i_threshold,
    output logic                        o_valid,
    output wc_pkg::t_result             o_result
);
    import wc_pkg::*;

    logic        [KEXT_W-1:0]    kext [3];
    logic signed [COEF_BITS-1:0] coef [9];
    logic signed [PROD_W-1:0]    n_prod [9];
    logic        [SOB_W-1:0]     sx_pos, sx_neg, sy_pos, sy_neg;

    logic signed [PROD_W-1:0]    r_prod [9];
    logic signed [SOB_W-1:0]     r_gx, r_gy;
    logic                        r_s3_valid;
    t_pos_meta                   r_s3_meta;

    logic        [MAG_W-1:0]     ax, ay;
    logic signed [ROWSUM_W-1:0]  r_rowsum [3];
    logic        [MAG_W-1:0]     r_mag;
    logic                        r_s4_valid;
    t_pos_meta                   r_s4_meta;

    logic signed [SUM_W-1:0]           total;
    logic        [SUM_W-FRAC_BITS-1:0] shifted;
    logic        [PIX_W-1:0]           kern_pix;
    logic        [PIX_W-1:0]           sob_sat;
    logic        [PIX_W-1:0]           sob_pix;

    assign kext[0] = KEXT_W'(i_kernel_top);
    assign kext[1] = KEXT_W'(i_kernel_middle);
    assign kext[2] = KEXT_W'(i_kernel_bottom);

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            coef[k]   = $signed(kext[k / 3][(k % 3) * COEF_BITS +: COEF_BITS]);
            n_prod[k] = $signed({1'b0, i_window[k]}) * coef[k];
        end
        sx_pos = SOB_W'(i_window[0]) + (SOB_W'(i_window[3]) << 1) + SOB_W'(i_window[6]);
        sx_neg = SOB_W'(i_window[2]) + (SOB_W'(i_window[5]) << 1) + SOB_W'(i_window[8]);
        sy_pos = SOB_W'(i_window[0]) + (SOB_W'(i_window[1]) << 1) + SOB_W'(i_window[2]);
        sy_neg = SOB_W'(i_window[6]) + (SOB_W'(i_window[7]) << 1) + SOB_W'(i_window[8]);
    end

    always_comb begin
        ax = r_gx[SOB_W-1] ? MAG_W'(-r_gx) : MAG_W'(r_gx);
        ay = r_gy[SOB_W-1] ? MAG_W'(-r_gy) : MAG_W'(r_gy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= i_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= n_prod[k];
            end
            r_gx      <= $signed(sx_pos - sx_neg);
            r_gy      <= $signed(sy_pos - sy_neg);
            r_s3_meta <= i_meta;
            for (int r = 0; r < 3; r++) begin
                r_rowsum[r] <= ROWSUM_W'(r_prod[r*3]) + ROWSUM_W'(r_prod[r*3 + 1])
                             + ROWSUM_W'(r_prod[r*3 + 2]);
            end
            r_mag     <= ax + ay;
            r_s4_meta <= r_s3_meta;
        end
    end

    // kernel: nonpositive -> 0, else drop fraction and clip at full scale
    always_comb begin
        total   = SUM_W'(r_rowsum[0]) + SUM_W'(r_rowsum[1]) + SUM_W'(r_rowsum[2]);
        shifted = total[SUM_W-1:FRAC_BITS];
        if (total <= 0) begin
            kern_pix = '0;
        end else if (shifted > PIX_MAX) begin
            kern_pix = PIX_W'(PIX_MAX);
        end else begin
            kern_pix = shifted[PIX_W-1:0];
        end
        sob_sat = (r_mag > PIX_MAX) ? PIX_W'(PIX_MAX) : r_mag[PIX_W-1:0];
        sob_pix = (sob_sat < i_threshold) ? '0 : sob_sat;
    end

    always_comb begin
        o_result.pix  = (i_mode == MODE_SOBEL) ? sob_pix : kern_pix;
        o_result.row  = r_s4_meta.row;
        o_result.col  = r_s4_meta.col;
        o_result.done = r_s4_meta.done;
    end

    assign o_valid = r_s4_valid;

endmodule

/* design/wc_out_skid.sv */
// wc_out_skid: output register plus one skid entry; upstream ready is registered.
// Depends on wc_pkg.
module wc_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  wc_pkg::t_result   i_data,
    output logic              o_ready,
    output logic              o_valid,
    output wc_pkg::t_result   o_data,
    input  logic              i_ready
);
    import wc_pkg::*;

    logic    r_main_v;
    logic    r_skid_v;
    t_result r_main;
    t_result r_skid;
    logic    in_fire;

    assign o_ready = !r_skid_v;
    assign in_fire = i_valid & !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_main_v || i_ready) begin
            if (r_skid_v) begin
                r_main_v <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_v || i_ready) begin
            r_main <= r_skid_v ? r_skid : i_data;
        end else if (in_fire) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_main_v;
    assign o_data  = r_main;

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_main_v)
        else $error("skid entry held with empty output register");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_ready) |=> r_main_v && !r_skid_v)
        else $error("skid entry not moved on a taken beat");

endmodule

/* design/window_convolution_3x3.sv */
// window_convolution_3x3: top level, config registers and stream ports of the 3x3 filter.
// Depends on wc_pkg, wc_front, wc_line_ram, wc_datapath and wc_out_skid.
//
//  channel   direction  handshake                      beat contents (low bit first)
//  s_axis    in         s_axis_tvalid/s_axis_tready    tdata: pixel_in; tuser: frame_start
//  m_axis    out        m_axis_tvalid/m_axis_tready    tdata: pixel_out,out_row,out_column;
//                                                      tlast: frame_done
//  cfg       in         i_cfg_valid/o_cfg_ready        index, 36-bit write data
//
// One pixel per clock sustained while m_axis keeps up. A result reaches m_axis from its
// completing pixel through registered steps in order: line memory read, window shift,
// products, row sums; the output register follows.
// The line memory is one read and one write per cycle (1024 x 16); a read of the
// column being written in the same cycle is forwarded.
// Reset clears position and valid bits and sets config to defaults; the line memory is
// not cleared, so no clearing pass, and the block takes pixels right after reset.
// When m_axis stalls, one more result fits in the skid entry; then the whole
// pipeline holds and s_axis_tready drops.
module window_convolution_3x3 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel stream in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [wc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] pixel_in
    input  logic [0:0]                      s_axis_tuser,   // [0] frame_start
    // filtered stream out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [wc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [7:0] pixel_out,
                                                            // [17:8] out_row,
                                                            // [27:18] out_column, rest 0
    output logic                            m_axis_tlast,   // frame_done
    // config write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import wc_pkg::*;

    logic                 r_mode;
    logic [KROW_W-1:0]    r_kernel_top;
    logic [KROW_W-1:0]    r_kernel_middle;
    logic [KROW_W-1:0]    r_kernel_bottom;
    logic [PIX_W-1:0]     r_threshold;
    logic [CFG_DIM_W-1:0] r_width;
    logic [CFG_DIM_W-1:0] r_height;

    logic [DIM_W-1:0]     width_c;
    logic [DIMH_W-1:0]    height_c;

    logic                 en;
    logic                 win_valid;
    t_window              window;
    t_pos_meta            win_meta;
    logic                 res_valid;
    t_result              res_data;
    t_result              out_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_KERNEL;
            r_kernel_top    <= KERNEL_RESET;
            r_kernel_middle <= KERNEL_RESET;
            r_kernel_bottom <= KERNEL_RESET;
            r_threshold     <= THRESH_RESET;
            r_width         <= WIDTH_RESET;
            r_height        <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FILTER_MODE:   r_mode          <= i_cfg_data[0];
                CFG_KERNEL_TOP:    r_kernel_top    <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_MIDDLE: r_kernel_middle <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_BOTTOM: r_kernel_bottom <= i_cfg_data[KROW_W-1:0];
                CFG_EDGE_THRESH:   r_threshold     <= i_cfg_data[PIX_W-1:0];
                CFG_FRAME_WIDTH:   r_width         <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_FRAME_HEIGHT:  r_height        <= i_cfg_data[CFG_DIM_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // geometry clamped to 3..max
    always_comb begin
        if (r_width < 3) begin
            width_c = DIM_W'(3);
        end else if (r_width > MAX_LINE) begin
            width_c = DIM_W'(MAX_LINE);
        end else begin
            width_c = DIM_W'(r_width);
        end
        if (r_height < 3) begin
            height_c = DIMH_W'(3);
        end else if (r_height > ROW_LIMIT) begin
            height_c = DIMH_W'(ROW_LIMIT);
        end else begin
            height_c = DIMH_W'(r_height);
        end
    end

    // whole pipeline steps together while the skid entry is free
    assign s_axis_tready = en;

    wc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_pix_valid   (s_axis_tvalid),
        .i_pix         (s_axis_tdata[PIX_W-1:0]),
        .i_frame_start (s_axis_tuser[0]),
        .i_width       (width_c),
        .i_height      (height_c),
        .o_win_valid   (win_valid),
        .o_window      (window),
        .o_meta        (win_meta)
    );

    wc_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (win_valid),
        .i_window        (window),
        .i_meta          (win_meta),
        .i_mode          (r_mode),
        .i_kernel_top    (r_kernel_top),
        .i_kernel_middle (r_kernel_middle),
        .i_kernel_bottom (r_kernel_bottom),
        .i_threshold     (r_threshold),
        .o_valid         (res_valid),
        .o_result        (res_data)
    );

    wc_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res_data),
        .o_ready (en),
        .o_valid (m_axis_tvalid),
        .o_data  (out_data),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - PIX_W - 2 * OUT_POS_W)'(0),
                           out_data.col, out_data.row, out_data.pix};
    assign m_axis_tlast = out_data.done;

endmodule
